@@ hw/rtl/rspl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspl_pkg
// Shared types and constants of the range smoother and proximity level block.
// ----------------------------------------------------------------------------
package rspl_pkg;

    localparam int RAW_W      = 16;
    localparam int SENSOR_W   = 2;
    localparam int MEAN_W     = 10;
    localparam int LIGHT_W    = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int USER_W     = 2;

    localparam logic [MEAN_W-1:0] RESET_FILL     = 10'd2;
    localparam logic [MEAN_W-1:0] MIN_RANGE_RST  = 10'd2;
    localparam logic [MEAN_W-1:0] MAX_RANGE_RST  = 10'd400;
    localparam logic [MEAN_W-1:0] NEAR_LIMIT_RST = 10'd5;
    localparam logic [MEAN_W-1:0] MID_LIMIT_RST  = 10'd10;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RANGE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RANGE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_LIMIT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MID_LIMIT  = 2'd3;

    localparam logic [LIGHT_W-1:0] LIGHT_NONE   = 2'd0;
    localparam logic [LIGHT_W-1:0] LIGHT_RED    = 2'd1;
    localparam logic [LIGHT_W-1:0] LIGHT_YELLOW = 2'd2;
    localparam logic [LIGHT_W-1:0] LIGHT_GREEN  = 2'd3;

    // output word layout
    localparam int OUT_SMOOTH_LSB  = 0;
    localparam int OUT_NEAREST_LSB = MEAN_W;
    localparam int OUT_FOUND_BIT   = 2 * MEAN_W;
    localparam int OUT_LIGHT_LSB   = 2 * MEAN_W + 1;
    localparam int OUT_PAD_W       = OUT_DATA_W - (2 * MEAN_W + 1 + LIGHT_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READ,
        ST_DRAIN,
        ST_MEAN,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic update;
        logic rd_en;
        logic mean_wr;
        logic scan;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sensor_ok;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/rspl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspl_ctrl
// Sequencer: clearing pass, ring update, window sum, mean, scan, emit.
// ----------------------------------------------------------------------------
module rspl_ctrl #(
    parameter int SENSOR_COUNT  = 4,
    parameter int WINDOW_LENGTH = 8,
    parameter int DEPTH         = 32,
    parameter int CNT_W         = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rspl_pkg::t_dp_stat i_stat,
    output rspl_pkg::t_dp_cmd  o_cmd,
    output logic [CNT_W-1:0]   o_cnt
);

    rspl_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rspl_pkg::ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rspl_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (r_cnt == CNT_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = rspl_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rspl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rspl_pkg::ST_UPDATE;
                end
            end
            rspl_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = i_stat.sensor_ok ? rspl_pkg::ST_READ : rspl_pkg::ST_SCAN;
            end
            rspl_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                if (r_cnt == CNT_W'(WINDOW_LENGTH - 1)) begin
                    n_cnt   = '0;
                    n_state = rspl_pkg::ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rspl_pkg::ST_DRAIN: begin
                n_state = rspl_pkg::ST_MEAN;
            end
            rspl_pkg::ST_MEAN: begin
                o_cmd.mean_wr = 1'b1;
                n_cnt         = '0;
                n_state       = rspl_pkg::ST_SCAN;
            end
            rspl_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_cnt == CNT_W'(SENSOR_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = rspl_pkg::ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rspl_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = rspl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = rspl_pkg::ST_CLEAR;
            end
        endcase
    end

    assign o_cnt = r_cnt;

endmodule

@@ hw/rtl/rspl_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspl_datapath
// Config registers, window memory, accumulator, reciprocal-multiply mean,
// nearest scan, light select and output register.
// ----------------------------------------------------------------------------
module rspl_datapath #(
    parameter int SENSOR_COUNT  = 4,
    parameter int WINDOW_LENGTH = 8,
    parameter int SIDX_W        = 2,
    parameter int SLOT_W        = 3,
    parameter int DEPTH         = 32,
    parameter int CNT_W         = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rspl_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rspl_pkg::MEAN_W-1:0]         i_cfg_wdata,
    input  logic [rspl_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic [rspl_pkg::USER_W-1:0]         i_in_user,
    input  rspl_pkg::t_dp_cmd                   i_cmd,
    input  logic [CNT_W-1:0]                    i_cnt,
    output rspl_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rspl_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic [rspl_pkg::USER_W-1:0]         o_out_user
);

    localparam int ADDR_W    = SIDX_W + SLOT_W;
    localparam int SUM_W     = SLOT_W + rspl_pkg::MEAN_W;
    localparam int EXT_W     = SIDX_W + rspl_pkg::SENSOR_W;
    localparam int MUL_SHIFT = SUM_W + SLOT_W;
    localparam int PROD_W    = SUM_W + MUL_SHIFT;
    localparam logic [MUL_SHIFT-1:0] RECIP =
        MUL_SHIFT'((2 ** MUL_SHIFT) / WINDOW_LENGTH + 1);

    logic [rspl_pkg::MEAN_W-1:0] r_min, r_max, r_near, r_mid;

    logic [rspl_pkg::RAW_W-1:0]    r_raw;
    logic [rspl_pkg::SENSOR_W-1:0] r_sensor;
    logic [SIDX_W-1:0]             r_sidx;
    logic                          r_ok;

    logic [rspl_pkg::MEAN_W-1:0] r_held   [SENSOR_COUNT];
    logic [SLOT_W-1:0]           r_pos    [SENSOR_COUNT];
    logic [rspl_pkg::MEAN_W-1:0] r_latest [SENSOR_COUNT];

    logic [rspl_pkg::MEAN_W-1:0] r_win [DEPTH];
    logic [rspl_pkg::MEAN_W-1:0] r_rdata;
    logic                        r_rd_vld;

    logic [SUM_W-1:0]            r_sum;
    logic [rspl_pkg::MEAN_W-1:0] r_smooth, r_nearest;
    logic                        r_found;

    logic                            r_out_valid;
    logic [rspl_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [rspl_pkg::USER_W-1:0]     r_out_user;

    logic [EXT_W-1:0]            w_sensor_ext;
    logic                        w_raw_ok;
    logic [rspl_pkg::MEAN_W-1:0] n_held;
    logic [SLOT_W-1:0]           n_pos;
    logic                        w_wr_en;
    logic [ADDR_W-1:0]           w_wr_addr, w_rd_addr;
    logic [rspl_pkg::MEAN_W-1:0] w_wr_data;
    logic [PROD_W-1:0]           w_prod;
    logic [rspl_pkg::MEAN_W-1:0] w_mean;
    logic [rspl_pkg::MEAN_W-1:0] w_scan_m;
    logic [rspl_pkg::LIGHT_W-1:0] w_light;
    logic                        w_out_free;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= rspl_pkg::MIN_RANGE_RST;
            r_max  <= rspl_pkg::MAX_RANGE_RST;
            r_near <= rspl_pkg::NEAR_LIMIT_RST;
            r_mid  <= rspl_pkg::MID_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rspl_pkg::CFG_MIN_RANGE:  r_min  <= i_cfg_wdata;
                rspl_pkg::CFG_MAX_RANGE:  r_max  <= i_cfg_wdata;
                rspl_pkg::CFG_NEAR_LIMIT: r_near <= i_cfg_wdata;
                rspl_pkg::CFG_MID_LIMIT:  r_mid  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input capture
    assign w_sensor_ext = {{SIDX_W{1'b0}}, i_in_user};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw    <= i_in_data[rspl_pkg::RAW_W-1:0];
            r_sensor <= i_in_user;
            r_sidx   <= w_sensor_ext[SIDX_W-1:0];
            r_ok     <= (w_sensor_ext < EXT_W'(SENSOR_COUNT));
        end
    end

    assign o_stat.sensor_ok = r_ok;

    // held value and ring position
    assign w_raw_ok = (r_raw == '0) ||
                      ((r_raw >= rspl_pkg::RAW_W'(r_min)) && (r_raw <= rspl_pkg::RAW_W'(r_max)));
    assign n_held   = w_raw_ok ? r_raw[rspl_pkg::MEAN_W-1:0] : r_held[r_sidx];
    assign n_pos    = (r_pos[r_sidx] == SLOT_W'(WINDOW_LENGTH - 1)) ? '0
                                                                   : r_pos[r_sidx] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSOR_COUNT; s++) begin
                r_held[s] <= rspl_pkg::RESET_FILL;
                r_pos[s]  <= '0;
            end
        end else if (i_cmd.update && r_ok) begin
            r_held[r_sidx] <= n_held;
            r_pos[r_sidx]  <= n_pos;
        end
    end

    // window memory
    assign w_wr_en   = i_cmd.clear || (i_cmd.update && r_ok);
    assign w_wr_addr = i_cmd.clear ? i_cnt[ADDR_W-1:0] : {r_sidx, r_pos[r_sidx]};
    assign w_wr_data = i_cmd.clear ? rspl_pkg::RESET_FILL : n_held;
    assign w_rd_addr = {r_sidx, i_cnt[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_win[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_win[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    // accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_sum <= '0;
        end else if (r_rd_vld) begin
            r_sum <= r_sum + SUM_W'(r_rdata);
        end
    end

    // mean: truncated sum / WINDOW_LENGTH by reciprocal multiplication
    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign w_mean = w_prod[MUL_SHIFT +: rspl_pkg::MEAN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SENSOR_COUNT; s++) begin
                r_latest[s] <= rspl_pkg::RESET_FILL;
            end
        end else if (i_cmd.mean_wr) begin
            r_latest[r_sidx] <= w_mean;
        end
    end

    // nearest scan
    assign w_scan_m = r_latest[i_cnt[SIDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_smooth  <= '0;
            r_nearest <= '0;
            r_found   <= 1'b0;
        end else begin
            if (i_cmd.mean_wr) begin
                r_smooth <= w_mean;
            end
            if (i_cmd.scan && (w_scan_m != '0) && (!r_found || (w_scan_m < r_nearest))) begin
                r_nearest <= w_scan_m;
                r_found   <= 1'b1;
            end
        end
    end

    // light select
    always_comb begin
        priority if (!r_found) begin
            w_light = rspl_pkg::LIGHT_NONE;
        end else if (r_nearest <= r_near) begin
            w_light = rspl_pkg::LIGHT_RED;
        end else if (r_nearest <= r_mid) begin
            w_light = rspl_pkg::LIGHT_YELLOW;
        end else if (r_nearest <= r_max) begin
            w_light = rspl_pkg::LIGHT_GREEN;
        end else begin
            w_light = rspl_pkg::LIGHT_NONE;
        end
    end

    // output register
    assign w_out_free      = !r_out_valid || i_out_ready;
    assign o_stat.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {{rspl_pkg::OUT_PAD_W{1'b0}}, w_light, r_found, r_nearest, r_smooth};
            r_out_user <= r_sensor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

@@ hw/rtl/range_smoother_proximity_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_smoother_proximity_level
// Per-sensor ring-window mean of range readings and nearest-object light code.
//
// Channel   Dir  Contents
// s_axis    in   tdata: raw_distance; tuser: sensor
// m_axis    out  tdata: smoothed, nearest, found, light; tuser: sensor_echo
// cfg       in   i_cfg_we / i_cfg_addr / i_cfg_wdata, write only
//
// One word at a time: each word reads its WINDOW_LENGTH window entries in
// turn from the one-port memory, then scans the SENSOR_COUNT latest means;
// a word for an unknown sensor skips the read and mean steps.
// After reset a clearing pass fills all SENSOR_COUNT * 2**clog2(WINDOW_LENGTH)
// entries of the window memory; no word is taken during it.
// A stalled result waits in the output register; the next word is taken
// meanwhile and held at its final step until the register frees.
// ----------------------------------------------------------------------------
module range_smoother_proximity_level #(
    parameter int SENSOR_COUNT  = 4,
    parameter int WINDOW_LENGTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rspl_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] raw_distance
    input  logic [rspl_pkg::USER_W-1:0]         s_axis_tuser,  // [1:0] sensor
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] smoothed_distance, [19:10] nearest_distance, [20] nearest_found,
    // [22:21] light_code, [23] zero
    output logic [rspl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [rspl_pkg::USER_W-1:0]         m_axis_tuser,  // [1:0] sensor_echo
    input  logic                                i_cfg_we,
    input  logic [rspl_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rspl_pkg::MEAN_W-1:0]         i_cfg_wdata
);

    localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int SLOT_W = $clog2(WINDOW_LENGTH);
    localparam int ADDR_W = SIDX_W + SLOT_W;
    localparam int DEPTH  = SENSOR_COUNT * (2 ** SLOT_W);
    localparam int CNT_W  = ADDR_W;

    rspl_pkg::t_dp_cmd  w_cmd;
    rspl_pkg::t_dp_stat w_stat;
    logic [CNT_W-1:0]   w_cnt;

    rspl_ctrl #(
        .SENSOR_COUNT  (SENSOR_COUNT),
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .DEPTH         (DEPTH),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_cnt      (w_cnt)
    );

    rspl_datapath #(
        .SENSOR_COUNT  (SENSOR_COUNT),
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SIDX_W        (SIDX_W),
        .SLOT_W        (SLOT_W),
        .DEPTH         (DEPTH),
        .CNT_W         (CNT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (w_cmd),
        .i_cnt       (w_cnt),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    logic                         w_a_found;
    logic [rspl_pkg::MEAN_W-1:0]  w_a_nearest;
    logic [rspl_pkg::LIGHT_W-1:0] w_a_light;

    assign w_a_found   = m_axis_tdata[rspl_pkg::OUT_FOUND_BIT];
    assign w_a_nearest = m_axis_tdata[rspl_pkg::OUT_NEAREST_LSB +: rspl_pkg::MEAN_W];
    assign w_a_light   = m_axis_tdata[rspl_pkg::OUT_LIGHT_LSB +: rspl_pkg::LIGHT_W];

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a word is in progress");

    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("input taken before the clearing pass");

    a_none_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_a_found) |->
            ((w_a_light == rspl_pkg::LIGHT_NONE) && (w_a_nearest == '0)))
        else $error("light or nearest set with no object found");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_a_found) |-> (w_a_nearest != '0))
        else $error("nearest is zero although an object was found");

endmodule
